// ----- hdl/pbl_pkg.sv -----
// Shared types, constants and helper functions for the planar RGB blit core.
// Used by every module of the block; depends on nothing else.
package pbl_pkg;

   localparam int DEF_MAX_IMAGE_DIM  = 4096;
   localparam int DEF_MAX_SCREEN_DIM = 4096;

   localparam int DIM_W      = 13;
   localparam int PITCH_W    = 16;
   localparam int BASE_W     = 30;
   localparam int LEVEL_W    = 32;
   localparam int WORD_W     = 32;
   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] ALPHA_BYTE = 8'hFF;
   localparam logic [7:0] BYTE_MAX   = 8'hFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEST_X        = 4'd0,
      CSR_DEST_Y        = 4'd1,
      CSR_IMAGE_WIDTH   = 4'd2,
      CSR_IMAGE_HEIGHT  = 4'd3,
      CSR_SCREEN_WIDTH  = 4'd4,
      CSR_SCREEN_HEIGHT = 4'd5,
      CSR_LINE_PITCH    = 4'd6,
      CSR_FRAME_BASE    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [DIM_W-1:0] dest_x;
      logic signed [DIM_W-1:0] dest_y;
      logic [DIM_W-1:0]        image_width;
      logic [DIM_W-1:0]        image_height;
      logic [DIM_W-1:0]        screen_width;
      logic [DIM_W-1:0]        screen_height;
      logic [PITCH_W-1:0]      line_pitch;
      logic [BASE_W-1:0]       frame_base;
   } cfg_type;

   // Width of a column or row counter for a given largest image size.
   function automatic int count_width(input int max_dim);
      return $clog2(max_dim);
   endfunction

   // Width of a signed screen coordinate: offset plus counter plus sign.
   function automatic int coord_width(input int max_dim);
      int cw;
      cw = $clog2(max_dim) + 1;
      return ((cw > DIM_W) ? cw : DIM_W) + 1;
   endfunction

   // Q15.16 level times 255, truncated toward zero, clamped to 0..255.
   function automatic logic [7:0] channel_byte(input logic [LEVEL_W-1:0] level);
      logic [LEVEL_W+7:0] scaled;
      logic [LEVEL_W-9:0] whole;
      logic [7:0]         result;
      scaled = {level, 8'b0} - {8'b0, level};
      whole  = scaled[LEVEL_W+7:16];
      if (level[LEVEL_W-1]) begin
         result = 8'd0;
      end else if (whole > {{(LEVEL_W-16){1'b0}}, BYTE_MAX}) begin
         result = BYTE_MAX;
      end else begin
         result = whole[7:0];
      end
      return result;
   endfunction

endpackage

// ----- hdl/pbl_position_counter.sv -----
// Raster column and row counters giving each pixel's screen coordinate.
// Depends on pbl_pkg for the configuration struct and width helpers.
module pbl_position_counter #(
   parameter int MAX_IMAGE_DIM = pbl_pkg::DEF_MAX_IMAGE_DIM
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  pbl_pkg::cfg_type        cfg,
   output logic signed [pbl_pkg::coord_width(MAX_IMAGE_DIM)-1:0] pos_x,
   output logic signed [pbl_pkg::coord_width(MAX_IMAGE_DIM)-1:0] pos_y,
   output logic                    last_pixel
);

   localparam int CNT_W = pbl_pkg::count_width(MAX_IMAGE_DIM);
   localparam int CRD_W = pbl_pkg::coord_width(MAX_IMAGE_DIM);

   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [31:0]      width_eff, height_eff;
   logic             row_end, last_row;

   // Zero counts as one, oversized values are capped at the largest image.
   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = 32'd1;
      end else if (32'(cfg.image_width) > 32'(MAX_IMAGE_DIM)) begin
         width_eff = 32'(MAX_IMAGE_DIM);
      end else begin
         width_eff = 32'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         height_eff = 32'd1;
      end else if (32'(cfg.image_height) > 32'(MAX_IMAGE_DIM)) begin
         height_eff = 32'(MAX_IMAGE_DIM);
      end else begin
         height_eff = 32'(cfg.image_height);
      end
   end

   assign row_end    = 32'(column_ff) >= (width_eff - 32'd1);
   assign last_row   = 32'(row_ff) >= (height_eff - 32'd1);
   assign last_pixel = row_end && last_row;

   assign pos_x = CRD_W'(cfg.dest_x) + CRD_W'($signed({1'b0, column_ff}));
   assign pos_y = CRD_W'(cfg.dest_y) + CRD_W'($signed({1'b0, row_ff}));

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (row_end) begin
            column_in = '0;
            row_in    = last_row ? '0 : row_ff + 1'b1;
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ----- hdl/pbl_pixel_format.sv -----
// Per-pixel datapath: color packing, byte address and screen clipping.
// Depends on pbl_pkg for the configuration struct and channel conversion.
module pbl_pixel_format #(
   parameter int MAX_IMAGE_DIM  = pbl_pkg::DEF_MAX_IMAGE_DIM,
   parameter int MAX_SCREEN_DIM = pbl_pkg::DEF_MAX_SCREEN_DIM
) (
   input  pbl_pkg::cfg_type                    cfg,
   input  logic signed [pbl_pkg::coord_width(MAX_IMAGE_DIM)-1:0] pos_x,
   input  logic signed [pbl_pkg::coord_width(MAX_IMAGE_DIM)-1:0] pos_y,
   input  logic [pbl_pkg::LEVEL_W-1:0]         red_level,
   input  logic [pbl_pkg::LEVEL_W-1:0]         green_level,
   input  logic [pbl_pkg::LEVEL_W-1:0]         blue_level,
   output logic                                write_enable,
   output logic [pbl_pkg::ADDR_W-1:0]          byte_address,
   output logic [pbl_pkg::WORD_W-1:0]          pixel_word
);

   logic [pbl_pkg::DIM_W-1:0] screen_w_eff, screen_h_eff;
   logic signed [31:0]        x_wide, y_wide;
   logic [31:0]               row_offset;
   logic                      x_inside, y_inside;

   always_comb begin
      if (32'(cfg.screen_width) > 32'(MAX_SCREEN_DIM)) begin
         screen_w_eff = pbl_pkg::DIM_W'(MAX_SCREEN_DIM);
      end else begin
         screen_w_eff = cfg.screen_width;
      end
      if (32'(cfg.screen_height) > 32'(MAX_SCREEN_DIM)) begin
         screen_h_eff = pbl_pkg::DIM_W'(MAX_SCREEN_DIM);
      end else begin
         screen_h_eff = cfg.screen_height;
      end
   end

   assign x_wide = 32'(pos_x);
   assign y_wide = 32'(pos_y);

   // Only the low 32 bits of the product matter; the address wraps.
   assign row_offset   = 32'(y_wide) * 32'(cfg.line_pitch);
   assign byte_address = 32'(cfg.frame_base) + row_offset + {x_wide[29:0], 2'b00};

   assign x_inside = !x_wide[31] && (x_wide < $signed({19'b0, screen_w_eff}));
   assign y_inside = !y_wide[31] && (y_wide < $signed({19'b0, screen_h_eff}));
   assign write_enable = (cfg.frame_base != '0) && x_inside && y_inside;

   assign pixel_word = {pbl_pkg::ALPHA_BYTE,
                        pbl_pkg::channel_byte(blue_level),
                        pbl_pkg::channel_byte(green_level),
                        pbl_pkg::channel_byte(red_level)};

endmodule

// ----- hdl/planar_rgb_to_packed_pixel_blit_core.sv -----
// Top level of the planar RGB blit core: register file, pipeline and handshakes.
// Depends on pbl_pkg, pbl_position_counter and pbl_pixel_format.
//
// This core takes pixels of an image in raster order, one per request
// transaction, each with red, green and blue levels in signed Q15.16, and
// returns one response transaction per pixel carrying the packed RGBA8888
// word (alpha 0xFF in the top byte, then blue, green, red), the frame buffer
// byte address frame_base + y*line_pitch + x*4 (modulo 2^32), a write enable
// that is set only when frame_base is nonzero and the pixel lands on screen,
// and an image_done flag on the last pixel of the image. Throughput is one
// pixel per clock with no bubbles while rsp_stall is low. The input register
// captures a pixel when its request is accepted, and the result register
// captures its response once the result register is empty or its response
// is being taken; the response then shows on rsp_valid until it is taken.
// The column and row counters wrap to the image origin after the last pixel.
// Configuration registers may only be written while no pixel is in flight;
// csr_ready is always high.
module planar_rgb_to_packed_pixel_blit_core #(
   parameter int MAX_IMAGE_DIM  = pbl_pkg::DEF_MAX_IMAGE_DIM,
   parameter int MAX_SCREEN_DIM = pbl_pkg::DEF_MAX_SCREEN_DIM
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pbl_pkg::CSR_DATA_W-1:0]      csr_data,
   // Pixel request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pbl_pkg::LEVEL_W-1:0]  req_red_level,
   input  logic signed [pbl_pkg::LEVEL_W-1:0]  req_green_level,
   input  logic signed [pbl_pkg::LEVEL_W-1:0]  req_blue_level,
   // Pixel response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_write_enable,
   output logic [pbl_pkg::ADDR_W-1:0]          rsp_byte_address,
   output logic [pbl_pkg::WORD_W-1:0]          rsp_pixel_word,
   output logic                                rsp_image_done
);

   localparam int CRD_W = pbl_pkg::coord_width(MAX_IMAGE_DIM);

   pbl_pkg::cfg_type cfg_ff, cfg_in;

   // Input register stage.
   logic                          in_valid_ff, in_valid_in;
   logic [pbl_pkg::LEVEL_W-1:0]   red_ff, red_in;
   logic [pbl_pkg::LEVEL_W-1:0]   green_ff, green_in;
   logic [pbl_pkg::LEVEL_W-1:0]   blue_ff, blue_in;
   logic signed [CRD_W-1:0]       x_ff, x_in;
   logic signed [CRD_W-1:0]       y_ff, y_in;
   logic                          done_ff, done_in;

   // Result register stage.
   logic                          out_valid_ff, out_valid_in;
   logic                          we_ff, we_in;
   logic [pbl_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [pbl_pkg::WORD_W-1:0]    word_ff, word_in;
   logic                          out_done_ff, out_done_in;

   logic                          out_advance;
   logic                          req_accept;
   logic signed [CRD_W-1:0]       pos_x, pos_y;
   logic                          last_pixel;
   logic                          fmt_we;
   logic [pbl_pkg::ADDR_W-1:0]    fmt_addr;
   logic [pbl_pkg::WORD_W-1:0]    fmt_word;

   // The register file accepts a write in every cycle. Unknown indexes are
   // dropped, and each register keeps only the bits it needs.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbl_pkg::CSR_DEST_X:        cfg_in.dest_x        = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_DEST_Y:        cfg_in.dest_y        = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[pbl_pkg::DIM_W-1:0];
            pbl_pkg::CSR_LINE_PITCH:    cfg_in.line_pitch    = csr_data[pbl_pkg::PITCH_W-1:0];
            pbl_pkg::CSR_FRAME_BASE:    cfg_in.frame_base    = csr_data[pbl_pkg::BASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The result register moves whenever it is empty or being taken; the input
   // register moves whenever it is empty or can hand its pixel on. So while a
   // finished response waits, a new request is taken if the input stage is empty.
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !out_advance;
   assign req_accept  = req_valid && !req_stall;

   // The counters step on every accepted request, so the coordinate is
   // captured together with the pixel's levels.
   pbl_position_counter #(
      .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
   ) u_position (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .cfg        (cfg_ff),
      .pos_x      (pos_x),
      .pos_y      (pos_y),
      .last_pixel (last_pixel)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      done_in     = done_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         red_in      = req_red_level;
         green_in    = req_green_level;
         blue_in     = req_blue_level;
         x_in        = pos_x;
         y_in        = pos_y;
         done_in     = last_pixel;
      end else if (out_advance) begin
         in_valid_in = 1'b0;
      end
   end

   pbl_pixel_format #(
      .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
   ) u_format (
      .cfg          (cfg_ff),
      .pos_x        (x_ff),
      .pos_y        (y_ff),
      .red_level    (red_ff),
      .green_level  (green_ff),
      .blue_level   (blue_ff),
      .write_enable (fmt_we),
      .byte_address (fmt_addr),
      .pixel_word   (fmt_word)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      we_in        = we_ff;
      addr_in      = addr_ff;
      word_in      = word_ff;
      out_done_in  = out_done_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
         we_in        = fmt_we;
         addr_in      = fmt_addr;
         word_in      = fmt_word;
         out_done_in  = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x        <= '0;
         cfg_ff.dest_y        <= '0;
         cfg_ff.image_width   <= pbl_pkg::DIM_W'(1);
         cfg_ff.image_height  <= pbl_pkg::DIM_W'(1);
         cfg_ff.screen_width  <= '0;
         cfg_ff.screen_height <= '0;
         cfg_ff.line_pitch    <= '0;
         cfg_ff.frame_base    <= '0;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      done_ff     <= done_in;
      we_ff       <= we_in;
      addr_ff     <= addr_in;
      word_ff     <= word_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_byte_address = addr_ff;
   assign rsp_pixel_word   = word_ff;
   assign rsp_image_done   = out_done_ff;

endmodule
